[rtl/fdsd_pkg.sv]
// Shared constants and the segment lookup for the four-digit display driver.
// No dependencies; every other file in rtl imports it.
package fdsd_pkg;

    // Default number of digits shown
    localparam int FDSD_DIGIT_COUNT = 4;

    // Field widths of the request and result channels
    localparam int FDSD_VALUE_W = 16;
    localparam int FDSD_POINT_W = 8;
    localparam int FDSD_INDEX_W = 2;
    localparam int FDSD_SEG_W   = 8;
    localparam int FDSD_DIGIT_W = 4;

    // Reciprocal of ten scaled by 2^19, exact for every 16-bit dividend
    localparam int                    FDSD_RECIP_SHIFT = 19;
    localparam logic [FDSD_VALUE_W:0] FDSD_RECIP       = 17'd52429;

    // Decimal point sits in bit 0 of the segment byte
    localparam logic [FDSD_SEG_W-1:0] FDSD_POINT_BIT = 8'h01;

    // Decimal digit to segment byte; codes above nine map to all off
    function automatic logic [FDSD_SEG_W-1:0] fdsd_seg(input logic [FDSD_DIGIT_W-1:0] digit);
        logic [FDSD_SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 8'hFC;
            4'd1:    seg = 8'h60;
            4'd2:    seg = 8'hDA;
            4'd3:    seg = 8'hF2;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'hB6;
            4'd6:    seg = 8'h3E;
            4'd7:    seg = 8'hE0;
            4'd8:    seg = 8'hFE;
            4'd9:    seg = 8'hE6;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

[rtl/fdsd_in_if.sv]
// Request channel of the display driver: number and decimal-point position.
// Depends on fdsd_pkg for the field widths.
interface fdsd_in_if
    import fdsd_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [FDSD_VALUE_W-1:0] value;
    logic [FDSD_POINT_W-1:0] point_position;

    modport source (output valid, output value, output point_position, input ready);
    modport sink   (input valid, input value, input point_position, output ready);
endinterface

[rtl/fdsd_out_if.sv]
// Result channel of the display driver: one segment byte per digit.
// Depends on fdsd_pkg for the field widths.
interface fdsd_out_if
    import fdsd_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [FDSD_INDEX_W-1:0] digit_index;
    logic [FDSD_SEG_W-1:0]   segments;
    logic                    enable_active_high;
    logic                    last;

    modport source (output valid, output digit_index, output segments,
                    output enable_active_high, output last, input ready);
    modport sink   (input valid, input digit_index, input segments,
                    input enable_active_high, input last, output ready);
endinterface

[rtl/fdsd_digit_stage.sv]
// One pipeline stage of the driver: splits off one decimal digit by a
// reciprocal multiply and registers its segment byte. Depends on fdsd_pkg.
module fdsd_digit_stage
    import fdsd_pkg::*;
#(
    parameter int DIGIT_COUNT = FDSD_DIGIT_COUNT,
    parameter int STAGE       = 0
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [FDSD_VALUE_W-1:0]                  i_rest,
    input  logic [FDSD_POINT_W-1:0]                  i_point,
    input  logic [DIGIT_COUNT-1:0][FDSD_SEG_W-1:0]   i_segs,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic [FDSD_VALUE_W-1:0]                  o_rest,
    output logic [FDSD_POINT_W-1:0]                  o_point,
    output logic [DIGIT_COUNT-1:0][FDSD_SEG_W-1:0]   o_segs
);

    localparam int PROD_W = 2 * FDSD_VALUE_W + 1;

    logic                                   r_valid;
    logic [FDSD_VALUE_W-1:0]                r_rest;
    logic [FDSD_POINT_W-1:0]                r_point;
    logic [DIGIT_COUNT-1:0][FDSD_SEG_W-1:0] r_segs;

    logic [PROD_W-1:0]                      w_prod;
    logic [FDSD_VALUE_W-1:0]                w_quot;
    logic [FDSD_VALUE_W-1:0]                w_tens;
    logic [FDSD_DIGIT_W-1:0]                w_digit;
    logic [FDSD_SEG_W-1:0]                  w_seg;
    logic [FDSD_VALUE_W-1:0]                n_rest;
    logic [DIGIT_COUNT-1:0][FDSD_SEG_W-1:0] n_segs;

    // Accept when empty or when the next stage takes the held request
    assign o_ready = !r_valid || i_ready;

    // Divide by ten and recover the remainder as the digit
    always_comb begin
        w_prod  = PROD_W'(i_rest) * PROD_W'(FDSD_RECIP);
        w_quot  = FDSD_VALUE_W'(w_prod >> FDSD_RECIP_SHIFT);
        w_tens  = (w_quot << 3) + (w_quot << 1);
        w_digit = FDSD_DIGIT_W'(i_rest - w_tens);
        n_rest  = w_quot;
    end

    // Look up the segments and add the point on this place
    always_comb begin
        w_seg = fdsd_seg(w_digit);
        if (i_point == FDSD_POINT_W'(STAGE)) begin
            w_seg = w_seg | FDSD_POINT_BIT;
        end
        n_segs        = i_segs;
        n_segs[STAGE] = w_seg;
    end

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load the payload with each accepted request
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rest  <= n_rest;
            r_point <= i_point;
            r_segs  <= n_segs;
        end
    end

    assign o_valid = r_valid;
    assign o_rest  = r_rest;
    assign o_point = r_point;
    assign o_segs  = r_segs;

endmodule

[rtl/four_digit_seven_segment_driver_core.sv]
// Seven-segment display driver: each request (a 16-bit number and a decimal-point
// position) yields DIGIT_COUNT segment results, least significant digit first, one
// result per clock while the sink is ready. A request therefore holds the result
// port until its last digit is taken, and that port sets the sustained rate;
// requests keep entering the digit pipeline meanwhile. Before its first result
// appears, a request passes one registered divide-by-ten stage per digit, then
// the output serializer. Only the lowest DIGIT_COUNT decimal digits are shown,
// a point position of DIGIT_COUNT or more lights no point, and the two highest
// digits report an active-high enable. Depends on fdsd_pkg, fdsd_in_if, fdsd_out_if
// and fdsd_digit_stage.
module four_digit_seven_segment_driver_core
    import fdsd_pkg::*;
#(
    parameter int DIGIT_COUNT = FDSD_DIGIT_COUNT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fdsd_in_if.sink       i_in,
    fdsd_out_if.source    o_out
);

    localparam int CNT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGIT_COUNT - 1);

    // Pipeline links: entry k feeds stage k
    logic                                   w_valid [0:DIGIT_COUNT];
    logic                                   w_ready [0:DIGIT_COUNT];
    logic [FDSD_VALUE_W-1:0]                w_rest  [0:DIGIT_COUNT];
    logic [FDSD_POINT_W-1:0]                w_point [0:DIGIT_COUNT];
    logic [DIGIT_COUNT-1:0][FDSD_SEG_W-1:0] w_segs  [0:DIGIT_COUNT];

    // Serializer state
    logic                                   r_ser_valid;
    logic [CNT_W-1:0]                       r_cnt;
    logic [DIGIT_COUNT-1:0][FDSD_SEG_W-1:0] r_segs;
    logic                                   w_take;
    logic                                   w_is_last;
    logic                                   w_load;

    // Feed the request into the first stage
    assign w_valid[0] = i_in.valid;
    assign w_rest[0]  = i_in.value;
    assign w_point[0] = i_in.point_position;
    assign w_segs[0]  = '0;
    assign i_in.ready = w_ready[0];

    // One digit per stage
    for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_stage
        fdsd_digit_stage #(
            .DIGIT_COUNT (DIGIT_COUNT),
            .STAGE       (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_rest  (w_rest[k]),
            .i_point (w_point[k]),
            .i_segs  (w_segs[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_rest  (w_rest[k+1]),
            .o_point (w_point[k+1]),
            .o_segs  (w_segs[k+1])
        );
    end

    // Serializer takes a new request once the last digit of the held one leaves
    assign w_take    = r_ser_valid && o_out.ready;
    assign w_is_last = (r_cnt == CNT_LAST);
    assign w_load    = !r_ser_valid || (w_take && w_is_last);
    assign w_ready[DIGIT_COUNT] = w_load;

    // Advance the digit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
            r_cnt       <= '0;
        end else if (w_load) begin
            r_ser_valid <= w_valid[DIGIT_COUNT];
            r_cnt       <= '0;
        end else if (w_take) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // Hold the segment bytes of the request being sent
    always_ff @(posedge i_clk) begin
        if (w_load && w_valid[DIGIT_COUNT]) begin
            r_segs <= w_segs[DIGIT_COUNT];
        end
    end

    // Drive the result fields from the held request
    assign o_out.valid              = r_ser_valid;
    assign o_out.digit_index        = FDSD_INDEX_W'(r_cnt);
    assign o_out.segments           = r_segs[r_cnt];
    assign o_out.enable_active_high = (int'(r_cnt) + 2 >= DIGIT_COUNT);
    assign o_out.last               = w_is_last;

    // After the final digit the next result starts at index zero
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=> (o_out.digit_index == '0))
        else $error("digit index did not restart after final digit");

    // A digit that is not final is followed by the next digit of the same request
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=>
        (o_out.valid && o_out.digit_index == FDSD_INDEX_W'($past(o_out.digit_index) + 2'd1)))
        else $error("digit sequence broken inside a request");

    // The serializer never drops a pending request from the last stage
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[DIGIT_COUNT] && !w_ready[DIGIT_COUNT]) |=> w_valid[DIGIT_COUNT])
        else $error("pipeline request lost while serializer busy");

endmodule

[dv/fdsd_digit_checker.sv]
// Result checker for the four-digit display driver: watches both channels, predicts
// the digit results of every accepted request and compares them in order.
// Depends on fdsd_pkg, fdsd_in_if and fdsd_out_if.
module fdsd_digit_checker
    import fdsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    fdsd_in_if   i_req,
    fdsd_out_if  i_res,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_digits_seen
);

    localparam int unsigned RADIX      = 10;
    localparam int          MAX_REPORT = 10;

    // Segment bytes for digits 0..9, digit 0 in the low byte
    localparam logic [10*FDSD_SEG_W-1:0] SEGMENT_ROM = {
        8'hE6, 8'hFE, 8'hE0, 8'h3E, 8'hB6, 8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC
    };

    typedef struct packed {
        logic [FDSD_INDEX_W-1:0] digit_index;
        logic [FDSD_SEG_W-1:0]   segments;
        logic                    enable_active_high;
        logic                    last;
    } digit_result_t;

    digit_result_t digits_due[$];
    int            mismatch_count;

    // Split the number into decimal places and queue one expected digit per place
    task automatic decode_request(input logic [FDSD_VALUE_W-1:0] num,
                                  input logic [FDSD_POINT_W-1:0] point);
        int unsigned   rest;
        int unsigned   place_digit;
        digit_result_t r;
        rest = 32'(num);
        for (int unsigned i = 0; i < FDSD_DIGIT_COUNT; i++) begin
            place_digit          = rest % RADIX;
            r.digit_index        = i[FDSD_INDEX_W-1:0];
            r.segments           = SEGMENT_ROM[place_digit*FDSD_SEG_W +: FDSD_SEG_W];
            if (32'(point) == i) begin
                r.segments = r.segments | FDSD_POINT_BIT;
            end
            r.enable_active_high = (i + 2 >= FDSD_DIGIT_COUNT);
            r.last               = (i + 1 == FDSD_DIGIT_COUNT);
            digits_due.push_back(r);
            rest = rest / RADIX;
        end
    endtask

    // Predict on each accepted request, compare each accepted digit with the oldest one due
    always @(posedge i_clk) begin : watch
        digit_result_t got;
        digit_result_t want;
        if (!i_rst_n) begin
            digits_due.delete();
            mismatch_count = 0;
            o_mismatches  <= 0;
            o_pending     <= 0;
            o_digits_seen <= 0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                decode_request(i_req.value, i_req.point_position);
            end
            if (i_res.valid && i_res.ready) begin
                got.digit_index        = i_res.digit_index;
                got.segments           = i_res.segments;
                got.enable_active_high = i_res.enable_active_high;
                got.last               = i_res.last;
                o_digits_seen <= o_digits_seen + 1;
                if (digits_due.size() == 0) begin
                    if (mismatch_count < MAX_REPORT) begin
                        $display("checker: unexpected digit idx=%0d seg=%02h en_hi=%0b last=%0b",
                                 got.digit_index, got.segments,
                                 got.enable_active_high, got.last);
                    end
                    mismatch_count++;
                end else begin
                    want = digits_due.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < MAX_REPORT) begin
                            $display("checker: digit mismatch expected idx=%0d seg=%02h en_hi=%0b last=%0b",
                                     want.digit_index, want.segments,
                                     want.enable_active_high, want.last);
                            $display("checker:                got      idx=%0d seg=%02h en_hi=%0b last=%0b",
                                     got.digit_index, got.segments,
                                     got.enable_active_high, got.last);
                        end
                        mismatch_count++;
                    end
                end
            end
            o_mismatches <= mismatch_count;
            o_pending    <= digits_due.size();
        end
    end

endmodule

[dv/tb.sv]
// Top of the display driver testbench: clock, reset, request stimulus, result-side
// stalls and the verdict. Depends on fdsd_pkg, both channel interfaces, the core
// and fdsd_digit_checker.
module tb;
    import fdsd_pkg::*;

    localparam int DIRECTED_COUNT  = 14;
    localparam int RANDOM_COUNT    = 116;
    localparam int TOTAL_COUNT     = DIRECTED_COUNT + RANDOM_COUNT;
    localparam int CALM_COUNT      = 30;
    localparam int DRAIN_AT        = DIRECTED_COUNT + 70;
    localparam int HOLD_OFF_AFTER  = 40;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int SETTLE_CYCLES   = 2 * (FDSD_DIGIT_COUNT + 1);
    localparam int CYCLE_LIMIT     = 200000;

    // Extremes, wrap above 9999, every digit, every point position and points out of range
    localparam logic [FDSD_VALUE_W-1:0] DIRECTED_VALUES [DIRECTED_COUNT] = '{
        16'd0, 16'd65535, 16'd9999, 16'd10000, 16'd1234, 16'd5678, 16'd9012,
        16'd34567, 16'd40000, 16'd65535, 16'd1, 16'd9876, 16'd5, 16'd20000
    };
    localparam logic [FDSD_POINT_W-1:0] DIRECTED_POINTS [DIRECTED_COUNT] = '{
        8'd0, 8'd255, 8'd3, 8'd2, 8'd1, 8'd0, 8'd4,
        8'd3, 8'd255, 8'd0, 8'd128, 8'd2, 8'd15, 8'd1
    };

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   pending;
    int   digits_seen;
    int   requests_sent;
    int   cycle_count;
    bit   calm;

    fdsd_in_if  req_if ();
    fdsd_out_if res_if ();

    four_digit_seven_segment_driver_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    fdsd_digit_checker digit_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_if),
        .i_res         (res_if),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_digits_seen (digits_seen)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Offer one request and hold it until the core takes it
    task automatic offer_request(input logic [FDSD_VALUE_W-1:0] num,
                                 input logic [FDSD_POINT_W-1:0] point);
        req_if.valid          <= 1'b1;
        req_if.value          <= num;
        req_if.point_position <= point;
        do @(posedge i_clk); while (!req_if.ready);
        requests_sent++;
    endtask

    // Drop valid for a number of cycles, with junk on the payload
    task automatic idle_requests(input int cycles);
        req_if.valid          <= 1'b0;
        req_if.value          <= FDSD_VALUE_W'($urandom);
        req_if.point_position <= FDSD_POINT_W'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    // Request side: reset, directed requests, then random ones with bursts of idling
    initial begin : request_source
        logic [FDSD_VALUE_W-1:0] num;
        logic [FDSD_POINT_W-1:0] point;
        requests_sent          = 0;
        calm                   = 1'b0;
        i_rst_n               <= 1'b0;
        req_if.valid          <= 1'b0;
        req_if.value          <= '0;
        req_if.point_position <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < TOTAL_COUNT; k++) begin
            if (k < DIRECTED_COUNT) begin
                num   = DIRECTED_VALUES[k];
                point = DIRECTED_POINTS[k];
            end else begin
                case ($urandom_range(0, 3))
                    0:       num = FDSD_VALUE_W'($urandom_range(0, 9999));
                    1:       num = FDSD_VALUE_W'($urandom_range(9990, 10010));
                    default: num = FDSD_VALUE_W'($urandom_range(0, 65535));
                endcase
                point = FDSD_POINT_W'($urandom_range(0, 3) ? $urandom_range(0, 4)
                                                          : $urandom_range(0, 255));
            end
            calm = (k >= TOTAL_COUNT - CALM_COUNT);
            // Pause once until every digit already due has come out
            if (k == DRAIN_AT) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
                wait (pending == 0);
                @(posedge i_clk);
            end
            offer_request(num, point);
            if (!calm && $urandom_range(0, 2) == 0) begin
                idle_requests($urandom_range(1, 16));
            end
        end
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("tb: %0d requests sent, %0d digit results checked, %0d mismatches",
                 requests_sent, digits_seen, mismatches);
        $display("tb: covered value extremes, wrap above 9999, all point positions and stalls");
        if (mismatches == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Result side: random ready bursts, one long hold-off, always ready near the end
    initial begin : result_sink
        int  n;
        bit  held_off;
        held_off      = 1'b0;
        res_if.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        while (!calm) begin
            res_if.ready <= 1'b1;
            n = $urandom_range(1, 24);
            repeat (n) @(posedge i_clk);
            if (!held_off && requests_sent >= HOLD_OFF_AFTER) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                held_off = 1'b1;
            end else if ($urandom_range(0, 1)) begin
                res_if.ready <= 1'b0;
                n = $urandom_range(1, 16);
                repeat (n) @(posedge i_clk);
            end
        end
        res_if.ready <= 1'b1;
    end

    // Stop a hung run
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: timeout after %0d cycles", cycle_count);
        $display("tb: FAIL");
        $finish;
    end

endmodule
